// ===== hw/rtl/pet_pkg.sv =====
// pet_pkg: shared types and constants of the pointer event tracker.
// Holds the transfer payload structs, event and register codes, and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package pet_pkg;

    // Fixed field widths
    localparam int MODE_W     = 3;
    localparam int CODE_W     = 16;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 32;
    localparam int SMOOTH_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fixed-point layout
    localparam int FRAC_W    = 16;  // fraction bits of the calibrated value
    localparam int QUO_W     = 48;  // quotient bits of |value - offset| * 2^16 / scale
    localparam int MUL_STEPS = 17;  // bits of the smoothing weight
    localparam int ACC_SHIFT = 32;  // blend accumulator fraction bits

    localparam int COORD_BITS_DEF = 32;

    // Event kinds
    localparam logic [MODE_W-1:0] MODE_SYNC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_KEY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ABS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    // Axis codes
    localparam logic [CODE_W-1:0] AXIS_X = 16'd0;
    localparam logic [CODE_W-1:0] AXIS_Y = 16'd1;

    // Key values
    localparam logic [VAL_W-1:0] KEY_DOWN = 32'd1;
    localparam logic [VAL_W-1:0] KEY_UP   = 32'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd4;

    // Register reset values
    localparam logic [VAL_W-1:0]    SCALE_RST  = 32'd65536;
    localparam logic [SMOOTH_W-1:0] SMOOTH_RST = 17'd32768;
    localparam logic [SMOOTH_W-1:0] WEIGHT_ONE = 17'd65536;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [CODE_W-1:0]       event_code;
        logic signed [VAL_W-1:0] event_value;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    was_pressed;
        logic                    was_released;
        logic                    dragging;
    } t_out_item;

endpackage

// ===== hw/rtl/pointer_event_tracker.sv =====
// pointer_event_tracker: top level of the pointer event tracker.
// Depends on pet_pkg for payload types, event codes and register indexes.
`timescale 1ns / 1ps

// Takes one event at a time and returns one result per event. Sync, key,
// relative, read_clear and other events go from idle to the finish state,
// which loads the result register once the output is free. For an absolute
// event on axis 0 or 1, one shared adder does the offset subtract, the
// magnitude, a 48-step restoring divide (one quotient bit a cycle), then,
// while dragging, a 17-step shift-add multiply by the smoothing weight and
// a rounding step. Input ready is high only while the block is idle; the
// result sits in an output register, so the next event is taken while it
// waits. A scale of zero divides by one, and weights above one saturate.
module pointer_event_tracker #(
    parameter int COORD_BITS = pet_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pet_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pet_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [pet_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pet_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import pet_pkg::*;

    localparam int AW    = COORD_BITS + 34;          // shared adder width
    localparam int LW    = COORD_BITS + FRAC_W;      // calibrated value width
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] SAT_LIM = QUO_W'(1) << (COORD_BITS + FRAC_W - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIFF = 9'b000000010,
        S_ABS  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_CAL  = 9'b000010000,
        S_DLT  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_RND  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    // Control and architectural state
    t_state                       r_state, n_state;
    logic                         r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]      r_off_x, r_off_y;
    logic [VAL_W-1:0]             r_scale_x, r_scale_y;
    logic [SMOOTH_W-1:0]          r_smooth;
    logic signed [COORD_BITS-1:0] r_coord_x, n_coord_x, r_coord_y, n_coord_y;
    logic                         r_press, n_press, r_release, n_release;
    logic                         r_drag, n_drag;

    // Working registers
    logic [MODE_W-1:0]            r_mode, n_mode;
    logic                         r_axis_y, n_axis_y, r_axis_ok, n_axis_ok;
    logic signed [VAL_W-1:0]      r_val, n_val;
    logic                         r_neg, n_neg;
    logic [VAL_W:0]               r_mag, n_mag;
    logic [VAL_W-1:0]             r_rem, n_rem;
    logic [QUO_W-1:0]             r_num, n_num;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic signed [LW-1:0]         r_cal, n_cal;
    logic [AW-1:0]                r_mcand, n_mcand, r_acc, n_acc;
    logic [SMOOTH_W-1:0]          r_w, n_w;
    logic [COORD_BITS-1:0]        r_res, n_res;
    t_out_item                    r_out, n_out;

    // Shared adder
    logic [AW-1:0]                alu_a, alu_b, alu_sum;
    logic                         alu_sub;

    // Selected axis operands
    logic signed [VAL_W-1:0]      sel_off;
    logic [VAL_W-1:0]             sel_scale, div_d;
    logic signed [COORD_BITS-1:0] sel_old;
    logic [SMOOTH_W-1:0]          w_sat;
    logic [VAL_W:0]               div_t;
    logic                         div_ge;
    logic [QUO_W-1:0]             q_cap, q_sat;
    logic                         rnd_up;
    logic                         in_xfer, out_free;

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    assign sel_off   = r_axis_y ? r_off_y : r_off_x;
    assign sel_scale = r_axis_y ? r_scale_y : r_scale_x;
    assign div_d     = (sel_scale == '0) ? VAL_W'(1) : sel_scale;
    assign sel_old   = r_axis_y ? r_coord_y : r_coord_x;
    assign w_sat     = (r_smooth > WEIGHT_ONE) ? WEIGHT_ONE : r_smooth;
    assign div_t     = {r_rem, r_num[QUO_W-1]};
    assign div_ge    = ~alu_sum[AW-1];
    assign q_cap     = r_neg ? SAT_LIM : SAT_LIM - QUO_W'(1);
    assign q_sat     = (r_num > q_cap) ? q_cap : r_num;
    assign rnd_up    = r_acc[AW-1] & (|r_acc[ACC_SHIFT-1:0]);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_coord_x   = r_coord_x;
        n_coord_y   = r_coord_y;
        n_press     = r_press;
        n_release   = r_release;
        n_drag      = r_drag;
        n_mode      = r_mode;
        n_axis_y    = r_axis_y;
        n_axis_ok   = r_axis_ok;
        n_val       = r_val;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_num       = r_num;
        n_cnt       = r_cnt;
        n_cal       = r_cal;
        n_mcand     = r_mcand;
        n_acc       = r_acc;
        n_w         = r_w;
        n_res       = r_res;
        n_out       = r_out;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode    = i_in_data.mode;
                    n_val     = i_in_data.event_value;
                    n_axis_y  = (i_in_data.event_code == AXIS_Y);
                    n_axis_ok = (i_in_data.event_code == AXIS_X) ||
                                (i_in_data.event_code == AXIS_Y);
                    if (i_in_data.mode == MODE_ABS && n_axis_ok) begin
                        n_state = S_DIFF;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            // value - offset, exact in 33 bits
            S_DIFF: begin
                alu_a   = AW'(r_val);
                alu_b   = AW'(sel_off);
                alu_sub = 1'b1;
                n_mag   = alu_sum[VAL_W:0];
                n_neg   = alu_sum[VAL_W];
                n_state = S_ABS;
            end
            // take the magnitude and load the dividend
            S_ABS: begin
                alu_b   = AW'(r_mag);
                alu_sub = 1'b1;
                n_num   = {(r_neg ? alu_sum[VAL_W-1:0] : r_mag[VAL_W-1:0]),
                           {FRAC_W{1'b0}}};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            // restoring divide, one quotient bit a cycle
            S_DIV: begin
                alu_a   = AW'(div_t);
                alu_b   = AW'(div_d);
                alu_sub = 1'b1;
                n_rem   = div_ge ? alu_sum[VAL_W-1:0] : div_t[VAL_W-1:0];
                n_num   = {r_num[QUO_W-2:0], div_ge};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = S_CAL;
                end
            end
            // apply sign after saturation; without drag also drop the fraction
            S_CAL: begin
                alu_sub = r_neg;
                if (r_drag) begin
                    alu_b   = AW'(q_sat);
                    n_cal   = alu_sum[LW-1:0];
                    n_state = S_DLT;
                end else begin
                    alu_b   = AW'(q_sat >> FRAC_W);
                    n_res   = alu_sum[COORD_BITS-1:0];
                    n_state = S_FIN;
                end
            end
            // blend as old * 2^32 + (cal - old * 2^16) * w
            S_DLT: begin
                alu_a   = AW'(r_cal);
                alu_b   = AW'(sel_old) << FRAC_W;
                alu_sub = 1'b1;
                n_mcand = alu_sum;
                n_acc   = AW'(sel_old) << ACC_SHIFT;
                n_w     = w_sat;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            // shift-add multiply, weight bit zero first
            S_MUL: begin
                alu_a   = r_acc;
                alu_b   = r_mcand;
                if (r_w[0]) begin
                    n_acc = alu_sum;
                end
                n_mcand = r_mcand << 1;
                n_w     = r_w >> 1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_RND;
                end
            end
            // divide by 2^32 truncating toward zero
            S_RND: begin
                alu_a   = AW'($signed(r_acc) >>> ACC_SHIFT);
                alu_b   = AW'(rnd_up);
                n_res   = alu_sum[COORD_BITS-1:0];
                n_state = S_FIN;
            end
            // commit state and load the result register
            S_FIN: begin
                if (out_free) begin
                    if (r_mode == MODE_KEY) begin
                        if (r_val == KEY_DOWN) begin
                            n_press = 1'b1;
                            n_drag  = 1'b1;
                        end else if (r_val == KEY_UP) begin
                            n_release = 1'b1;
                            n_drag    = 1'b0;
                        end
                    end else if (r_mode == MODE_REL && r_axis_ok) begin
                        alu_a = AW'(sel_old);
                        alu_b = AW'(r_val);
                        if (r_axis_y) begin
                            n_coord_y = alu_sum[COORD_BITS-1:0];
                        end else begin
                            n_coord_x = alu_sum[COORD_BITS-1:0];
                        end
                    end else if (r_mode == MODE_ABS && r_axis_ok) begin
                        if (r_axis_y) begin
                            n_coord_y = r_res;
                        end else begin
                            n_coord_x = r_res;
                        end
                    end
                    n_out.pos_x        = POS_W'(n_coord_x);
                    n_out.pos_y        = POS_W'(n_coord_y);
                    n_out.was_pressed  = n_press;
                    n_out.was_released = n_release;
                    n_out.dragging     = n_drag;
                    if (r_mode == MODE_CLEAR) begin
                        n_press   = 1'b0;
                        n_release = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control, configuration and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_scale_x   <= SCALE_RST;
            r_scale_y   <= SCALE_RST;
            r_smooth    <= SMOOTH_RST;
            r_coord_x   <= '0;
            r_coord_y   <= '0;
            r_press     <= 1'b0;
            r_release   <= 1'b0;
            r_drag      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_coord_x   <= n_coord_x;
            r_coord_y   <= n_coord_y;
            r_press     <= n_press;
            r_release   <= n_release;
            r_drag      <= n_drag;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_OFFSET_X:  r_off_x   <= i_cfg_wdata;
                    REG_SCALE_X:   r_scale_x <= i_cfg_wdata;
                    REG_OFFSET_Y:  r_off_y   <= i_cfg_wdata;
                    REG_SCALE_Y:   r_scale_y <= i_cfg_wdata;
                    REG_SMOOTHING: r_smooth  <= i_cfg_wdata[SMOOTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_axis_y  <= n_axis_y;
        r_axis_ok <= n_axis_ok;
        r_val     <= n_val;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_rem     <= n_rem;
        r_num     <= n_num;
        r_cnt     <= n_cnt;
        r_cal     <= n_cal;
        r_mcand   <= n_mcand;
        r_acc     <= n_acc;
        r_w       <= n_w;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

// ===== hw/rtl/pet_checker.sv =====
// pet_checker: port-level checks of the pointer event tracker, bound to the top level.
// Depends on pet_pkg for the result payload type.
`timescale 1ns / 1ps

module pet_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pet_pkg::t_out_item o_out_data
);
    import pet_pkg::*;

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset leaves the block idle and ready
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

    // One event at a time: busy right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after input transfer");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind pointer_event_tracker pet_checker u_pet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== verif/pet_event_checker.sv =====
// pet_event_checker: watches the event, result and register channels of the
// pointer event tracker, predicts every result and compares it field by field.
// Depends on pet_pkg for payload types, event codes and register indexes.
`timescale 1ns / 1ps

module pet_event_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  pet_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  pet_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [pet_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pet_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import pet_pkg::*;

    localparam int MAX_REPORTS = 40;
    localparam int SAT_SHIFT   = COORD_BITS_DEF - 1 + FRAC_W;

    // Calibration registers as the block should hold them
    logic signed [VAL_W-1:0] cal_off_x;
    logic [VAL_W-1:0]        cal_scale_x;
    logic signed [VAL_W-1:0] cal_off_y;
    logic [VAL_W-1:0]        cal_scale_y;
    logic [SMOOTH_W-1:0]     blend_weight;

    // Pointer state
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic                    pressed_latch;
    logic                    released_latch;
    logic                    drag_on;

    t_out_item report_q[$];
    int        mismatches = 0;
    int        checked = 0;

    // Calibrate a raw reading and, while dragging, blend it into the old coordinate
    function automatic logic signed [POS_W-1:0] calibrate(
        input logic signed [POS_W-1:0] old_pos,
        input logic signed [VAL_W-1:0] raw,
        input logic signed [VAL_W-1:0] offset,
        input logic [VAL_W-1:0]        scale,
        input logic [SMOOTH_W-1:0]     weight,
        input logic                    drag
    );
        logic signed [79:0] raw80, off80, old80, diff, divisor, cal, lim, w, acc, res;
        raw80   = raw;
        off80   = offset;
        old80   = old_pos;
        diff    = raw80 - off80;
        divisor = (scale == '0) ? 80'sd1 : $signed({48'd0, scale});
        cal     = (diff * 80'sd65536) / divisor;
        lim     = 80'sd1 <<< SAT_SHIFT;
        // Saturate to the coordinate range in Q.16
        if (cal < -lim)
            cal = -lim;
        if (cal > lim - 80'sd1)
            cal = lim - 80'sd1;
        if (!drag) begin
            res = cal / 80'sd65536;
        end else begin
            w   = (weight > WEIGHT_ONE) ? 80'sd65536 : $signed({63'd0, weight});
            acc = old80 * 80'sd65536 * (80'sd65536 - w) + cal * w;
            res = acc / (80'sd1 <<< ACC_SHIFT);
        end
        return res[POS_W-1:0];
    endfunction

    // Apply one event to the pointer state and build the report it causes
    task automatic advance_pointer(input t_in_item ev, output t_out_item rep);
        case (ev.mode)
            MODE_KEY: begin
                if (ev.event_value == KEY_DOWN) begin
                    pressed_latch = 1'b1;
                    drag_on       = 1'b1;
                end else if (ev.event_value == KEY_UP) begin
                    released_latch = 1'b1;
                    drag_on        = 1'b0;
                end
            end
            MODE_REL: begin
                if (ev.event_code == AXIS_X)
                    cur_x = cur_x + ev.event_value;
                else if (ev.event_code == AXIS_Y)
                    cur_y = cur_y + ev.event_value;
            end
            MODE_ABS: begin
                if (ev.event_code == AXIS_X)
                    cur_x = calibrate(cur_x, ev.event_value, cal_off_x, cal_scale_x,
                                      blend_weight, drag_on);
                else if (ev.event_code == AXIS_Y)
                    cur_y = calibrate(cur_y, ev.event_value, cal_off_y, cal_scale_y,
                                      blend_weight, drag_on);
            end
            default: ;
        endcase
        rep.pos_x        = cur_x;
        rep.pos_y        = cur_y;
        rep.was_pressed  = pressed_latch;
        rep.was_released = released_latch;
        // Clear the sticky flags after reporting them
        if (ev.mode == MODE_CLEAR) begin
            pressed_latch  = 1'b0;
            released_latch = 1'b0;
        end
        rep.dragging = drag_on;
    endtask

    function automatic void note_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cal_off_x      = '0;
            cal_scale_x    = SCALE_RST;
            cal_off_y      = '0;
            cal_scale_y    = SCALE_RST;
            blend_weight   = SMOOTH_RST;
            cur_x          = '0;
            cur_y          = '0;
            pressed_latch  = 1'b0;
            released_latch = 1'b0;
            drag_on        = 1'b0;
            report_q.delete();
        end else begin
            // Compare a result transfer with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, actual %h",
                                 $time, i_out_data);
                end else begin
                    want = report_q.pop_front();
                    checked++;
                    note_field("pos_x", want.pos_x, i_out_data.pos_x);
                    note_field("pos_y", want.pos_y, i_out_data.pos_y);
                    note_field("was_pressed", 32'(want.was_pressed),
                               32'(i_out_data.was_pressed));
                    note_field("was_released", 32'(want.was_released),
                               32'(i_out_data.was_released));
                    note_field("dragging", 32'(want.dragging), 32'(i_out_data.dragging));
                end
            end
            // Predict the result of an event transfer
            if (i_in_valid && i_in_ready) begin
                advance_pointer(i_in_data, want);
                report_q.push_back(want);
            end
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X:  cal_off_x    = i_cfg_wdata;
                    REG_SCALE_X:   cal_scale_x  = i_cfg_wdata;
                    REG_OFFSET_Y:  cal_off_y    = i_cfg_wdata;
                    REG_SCALE_Y:   cal_scale_y  = i_cfg_wdata;
                    REG_SMOOTHING: blend_weight = i_cfg_wdata[SMOOTH_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= report_q.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
    end

endmodule

// ===== verif/pointer_event_tracker_tb.sv =====
// pointer_event_tracker_tb: drives events, register writes and output stalls
// into the pointer event tracker and gives the verdict from pet_event_checker.
// Depends on pet_pkg, pointer_event_tracker and pet_event_checker.
`timescale 1ns / 1ps

module pointer_event_tracker_tb;
    import pet_pkg::*;

    localparam logic [VAL_W-1:0]     VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]     VAL_MIN    = 32'h8000_0000;
    localparam logic [VAL_W-1:0]     SCALE_TOP  = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0]     WEIGHT_TOP = 32'h0001_FFFF;
    localparam logic [CODE_W-1:0]    AXIS_NONE  = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
    localparam int N_PHASES     = 8;
    localparam int PHASE_EVENTS = 150;
    localparam int LONG_HOLD    = 400;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_STRIDE} t_ready_style;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;

    int events_sent = 0;
    int abs_sent = 0;
    int cfg_writes = 0;
    int settings = 0;
    int burst_left = 1;
    int hold_req_cnt = 0;
    logic signed [VAL_W-1:0] tb_off_x = '0;
    logic signed [VAL_W-1:0] tb_off_y = '0;

    pointer_event_tracker uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    pet_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: windows of different stall styles, plus one long hold-off on request
    always @(posedge clk) begin
        static t_ready_style style = RDY_ALWAYS;
        static int window_left = 0;
        static int hold_left = 0;
        static int stride_cnt = 0;
        static int hold_done = 0;
        if (hold_req_cnt != hold_done) begin
            hold_done = hold_req_cnt;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (window_left == 0) begin
                style       = t_ready_style'($urandom_range(3));
                window_left = $urandom_range(128, 16);
            end
            window_left--;
            stride_cnt++;
            case (style)
                RDY_ALWAYS: out_ready <= 1'b1;
                RDY_COIN:   out_ready <= 1'($urandom_range(1));
                RDY_SPARSE: out_ready <= ($urandom_range(3) == 0);
                default:    out_ready <= (stride_cnt % 5 != 0);
            endcase
        end
    end

    function automatic t_in_item mk_event(input logic [MODE_W-1:0] mode,
                                          input logic [CODE_W-1:0] code,
                                          input logic [VAL_W-1:0] value);
        t_in_item ev;
        ev.mode        = mode;
        ev.event_code  = code;
        ev.event_value = value;
        return ev;
    endfunction

    // Offer one event and hold it until transfer; gaps come between bursts
    task automatic send_event(input t_in_item ev);
        int gap;
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
        if (ev.mode == MODE_ABS)
            abs_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
            gap = ($urandom_range(5) == 0) ? $urandom_range(90, 10) : $urandom_range(6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every result is back
    task automatic settle_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic load_calibration(input logic [31:0] off_x, input logic [31:0] scale_x,
                                    input logic [31:0] off_y, input logic [31:0] scale_y,
                                    input logic [31:0] weight);
        write_reg(REG_OFFSET_X, off_x);
        write_reg(REG_SCALE_X, scale_x);
        write_reg(REG_OFFSET_Y, off_y);
        write_reg(REG_SCALE_Y, scale_y);
        write_reg(REG_SMOOTHING, weight);
        cfg_we   <= 1'b0;
        tb_off_x = off_x;
        tb_off_y = off_y;
        settings++;
    endtask

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(4))
            0:       return '0;
            1:       return VAL_MIN;
            2:       return VAL_MAX;
            3:       return $urandom;
            default: return $urandom_range(4095) - 2048;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(6))
            0:       return '0;
            1:       return 32'd1;
            2:       return SCALE_RST;
            3:       return SCALE_TOP;
            4:       return $urandom;
            default: return $urandom_range(32'h0010_0000, 32'd256);
        endcase
    endfunction

    function automatic t_in_item random_event();
        t_in_item ev;
        int unsigned pick;
        pick           = $urandom_range(99);
        ev.event_code  = $urandom_range(1) ? AXIS_Y : AXIS_X;
        ev.event_value = $urandom_range(8191) - 4096;
        ev.mode        = MODE_SYNC;
        if (pick < 35) begin
            ev.mode = MODE_ABS;
            case ($urandom_range(3))
                0: ev.event_value = $urandom;
                1: ev.event_value = ((ev.event_code == AXIS_Y) ? tb_off_y : tb_off_x)
                                    + ($urandom_range(32'h0010_0000) - 32'h0008_0000);
                default: ;
            endcase
        end else if (pick < 55) begin
            ev.mode = MODE_REL;
            if ($urandom_range(7) == 0)
                ev.event_value = $urandom;
        end else if (pick < 73) begin
            ev.mode        = MODE_KEY;
            ev.event_code  = CODE_W'($urandom);
            ev.event_value = $urandom_range(1) ? KEY_DOWN : KEY_UP;
            if ($urandom_range(9) == 0)
                ev.event_value = $urandom;
        end else if (pick < 81) begin
            ev.mode = MODE_CLEAR;
        end else if (pick >= 86) begin
            // Noise: any mode, code and value
            ev.mode        = MODE_W'($urandom_range(7));
            ev.event_code  = CODE_W'($urandom);
            ev.event_value = $urandom;
        end
        return ev;
    endfunction

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset calibration, wrap, ignored codes and keys, flag clears
        send_event(mk_event(MODE_SYNC, AXIS_X, '0));
        send_event(mk_event(MODE_SPARE_HI, AXIS_NONE, SCALE_TOP));
        send_event(mk_event(MODE_REL, AXIS_X, VAL_MAX));
        send_event(mk_event(MODE_REL, AXIS_X, 32'd1));
        send_event(mk_event(MODE_REL, AXIS_Y, VAL_MIN));
        send_event(mk_event(MODE_REL, AXIS_Y, SCALE_TOP));
        send_event(mk_event(MODE_REL, 16'd2, 32'd5));
        send_event(mk_event(MODE_ABS, AXIS_X, 32'd100));
        send_event(mk_event(MODE_KEY, AXIS_NONE, KEY_DOWN));
        send_event(mk_event(MODE_ABS, AXIS_Y, -32'sd100));
        send_event(mk_event(MODE_KEY, AXIS_X, 32'd2));
        send_event(mk_event(MODE_KEY, AXIS_X, SCALE_TOP));
        send_event(mk_event(MODE_CLEAR, AXIS_X, '0));
        send_event(mk_event(MODE_KEY, AXIS_Y, KEY_UP));
        send_event(mk_event(MODE_CLEAR, AXIS_NONE, VAL_MAX));
        send_event(mk_event(MODE_CLEAR, AXIS_X, '0));
        send_event(mk_event(MODE_ABS, AXIS_NONE, 32'd77));
        send_event(mk_event(MODE_ABS, AXIS_X, VAL_MAX));
        send_event(mk_event(MODE_ABS, AXIS_Y, VAL_MIN));

        // Directed: zero scale, widest differences, weight above one
        settle_all();
        load_calibration(VAL_MIN, '0, VAL_MAX, SCALE_TOP, WEIGHT_TOP);
        send_event(mk_event(MODE_ABS, AXIS_X, VAL_MAX));
        send_event(mk_event(MODE_ABS, AXIS_Y, VAL_MIN));
        send_event(mk_event(MODE_KEY, AXIS_X, KEY_DOWN));
        send_event(mk_event(MODE_ABS, AXIS_X, '0));
        send_event(mk_event(MODE_ABS, AXIS_Y, '0));
        send_event(mk_event(MODE_SPARE_LO, AXIS_X, '0));

        // Directed: zero weight keeps the old coordinate while dragging
        settle_all();
        load_calibration('0, 32'd1, '0, SCALE_RST, '0);
        send_event(mk_event(MODE_ABS, AXIS_X, 32'd12345));
        send_event(mk_event(MODE_KEY, AXIS_X, KEY_UP));

        // Random phases, each under its own calibration
        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle_all();
            write_reg(REG_UNUSED, $urandom);
            load_calibration(pick_offset(), pick_scale(), pick_offset(), pick_scale(),
                             ($urandom_range(2) == 0)
                                 ? {15'($urandom_range(32'h7FFF)),
                                    17'($urandom_range(4) * 16384)}
                                 : 32'($urandom_range(WEIGHT_TOP)));
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (phase == 2 && n == 40)
                    hold_req_cnt++;
                send_event(random_event());
            end
        end

        // Drain and let the block go quiet
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Sent %0d events (%0d absolute) under %0d calibration settings, %0d register writes.",
                 events_sent, abs_sent, settings, cfg_writes);
        $display("Checked %0d results across output stalls, a long hold-off and drained phases.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #24_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
